// ===== hw/rtl/lrc_pkg.sv =====
// Shared widths, opcodes and word layout of the LRU result cache.
package lrc_pkg;

    // Field widths
    localparam int KEY_W   = 64;
    localparam int SCORE_W = 64;
    localparam int TIME_W  = 32;
    localparam int CAP_W   = 5;
    localparam int TTL_W   = 31;
    localparam int CNT_W   = 32;
    localparam int USED_W  = 5;
    localparam int OP_W    = 2;

    // Operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Register indexes, selected by paddr[2]
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_TTL      = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Input word layout
    localparam int IN_KEY_LSB   = 0;
    localparam int IN_SCORE_LSB = IN_KEY_LSB + KEY_W;
    localparam int IN_NOW_LSB   = IN_SCORE_LSB + SCORE_W;
    localparam int IN_DATA_W    = 160;

    // Output word layout
    localparam int OUT_SCORE_LSB = 0;
    localparam int OUT_USED_LSB  = OUT_SCORE_LSB + SCORE_W;
    localparam int OUT_HITS_LSB  = OUT_USED_LSB + USED_W;
    localparam int OUT_MISS_LSB  = OUT_HITS_LSB + CNT_W;
    localparam int OUT_FILL_LSB  = OUT_MISS_LSB + CNT_W;
    localparam int OUT_DATA_W    = 136;

endpackage

// ===== hw/rtl/lrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/lru_result_cache_ttl.sv =====
// Top level of the fully associative LRU result cache with entry time-to-live.
//
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the opcode (lookup,
//   insert/update, clear), s_tdata the key, the score word and the current
//   time. Each request yields one result word on the m_ stream: m_tuser is
//   the hit flag, m_tdata the score (zero unless hit), the fill level and the
//   saturating hit and miss counters after the request.
//   Lookup and insert walk the key store one entry per cycle through the
//   single read port of the key/score/stamp RAMs, compare in one shared
//   comparator, then check age (check state) and update recency (apply state).
//   Clear and unused opcodes skip the scan and go straight to the apply
//   state. s_tready is high only while the sequencer is idle, so a new
//   request is taken only after the last one has left the sequencer.
//   The result sits in an output register: a new request is accepted while
//   it waits, and the sequencer holds its final step until m_tready frees it.
//   Reset empties the store, zeroes recency and counters, and loads capacity
//   16 and time-to-live 0 (no expiry). No clearing pass is needed.
//   Registers (APB, byte address): 0x0 capacity_in_use, 0x4 ttl_ms.
module lru_result_cache_ttl
    import lrc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // s_tdata: lookup_key [63:0], new_score [127:64], now_ms [159:128]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: op [1:0]
    input  logic [OP_W-1:0]       s_tuser,
    // m_tdata: score_out [63:0], entries_used [68:64], hit_count [100:69],
    //          miss_count [132:101], zero fill [135:133]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    // m_tuser: hit [0]
    output logic                  m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW = $clog2(CACHE_ENTRIES);
    localparam int IW = $clog2(CACHE_ENTRIES + 1);
    localparam int FW = $clog2(CACHE_ENTRIES + 1);
    localparam int CW = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_APPLY
    } state_t;

    // Control state
    state_t             state_reg, state_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               cmp_en_reg;
    logic [AW-1:0]      cmp_idx_reg;
    logic [CACHE_ENTRIES-1:0] valid_reg, valid_next;
    logic [AW-1:0]      rank_reg [CACHE_ENTRIES];
    logic [AW-1:0]      rank_next [CACHE_ENTRIES];
    logic [FW-1:0]      fill_reg, fill_next;
    logic [CNT_W-1:0]   hits_reg, hits_next;
    logic [CNT_W-1:0]   miss_reg, miss_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [TTL_W-1:0]   ttl_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    logic [SCORE_W-1:0] out_score_reg, out_score_next;
    logic [USED_W-1:0]  out_used_reg, out_used_next;
    logic [CNT_W-1:0]   out_hits_reg;
    logic [CNT_W-1:0]   out_miss_reg;

    // Request and scan results
    logic [OP_W-1:0]    op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SCORE_W-1:0] new_score_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               found_reg;
    logic [AW-1:0]      hit_slot_reg;
    logic [AW-1:0]      hit_rank_reg;
    logic [SCORE_W-1:0] score_cap_reg;
    logic [TIME_W-1:0]  stamp_cap_reg;
    logic [AW-1:0]      evict_slot_reg;
    logic               free_found_reg;
    logic [AW-1:0]      free_slot_reg;
    logic               fresh_reg;

    // RAM ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [KEY_W-1:0]   key_rd;
    logic [SCORE_W-1:0] score_rd;
    logic [TIME_W-1:0]  stamp_rd;

    logic               accept;
    logic               apply_go;
    logic               scan_issue;
    logic               key_match;
    logic [AW-1:0]      oldest_rank;
    logic [CW-1:0]      cap_eff;
    logic               store_full;
    logic [AW-1:0]      ins_slot;
    logic [TIME_W-1:0]  age;
    logic               cfg_write;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign apply_go   = (state_reg == ST_APPLY) && (!out_valid_reg || m_tready);
    assign scan_issue = (state_reg == ST_SCAN) && (idx_reg != IW'(CACHE_ENTRIES));
    assign key_match  = cmp_en_reg && valid_reg[cmp_idx_reg] && (key_rd == key_reg);
    assign oldest_rank = AW'(fill_reg - FW'(1));

    // Clamp capacity into 1..CACHE_ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (CW'(cap_reg) > CW'(CACHE_ENTRIES))
        begin
            cap_eff = CW'(CACHE_ENTRIES);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    assign store_full = CW'(fill_reg) >= cap_eff;
    assign ins_slot   = store_full ? evict_slot_reg : free_slot_reg;
    assign age        = now_reg - stamp_cap_reg;

    // Write all three stores at the hit slot or the insert slot
    assign ram_we    = apply_go && (op_reg == OP_INSERT);
    assign ram_waddr = found_reg ? hit_slot_reg : ins_slot;

    lrc_ram #(.WIDTH(KEY_W), .DEPTH(CACHE_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (key_rd)
    );

    lrc_ram #(.WIDTH(SCORE_W), .DEPTH(CACHE_ENTRIES)) u_score_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (new_score_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (score_rd)
    );

    lrc_ram #(.WIDTH(TIME_W), .DEPTH(CACHE_ENTRIES)) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (now_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (stamp_rd)
    );

    // Sequencer next state and store updates
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        rank_next      = rank_reg;
        fill_next      = fill_reg;
        hits_next      = hits_reg;
        miss_next      = miss_reg;
        out_hit_next   = out_hit_reg;
        out_score_next = out_score_reg;
        out_used_next  = out_used_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    if ((s_tuser == OP_LOOKUP) || (s_tuser == OP_INSERT))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_issue)
                begin
                    idx_next = idx_reg + IW'(1);
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (apply_go)
                begin
                    out_hit_next   = 1'b0;
                    out_score_next = '0;
                    case (op_reg)
                        OP_LOOKUP:
                        begin
                            if (fresh_reg)
                            begin
                                // promote the hit entry
                                for (int j = 0; j < CACHE_ENTRIES; j++)
                                begin
                                    if (valid_reg[j] && (rank_reg[j] < hit_rank_reg))
                                    begin
                                        rank_next[j] = rank_reg[j] + AW'(1);
                                    end
                                end
                                rank_next[hit_slot_reg] = '0;
                                out_hit_next   = 1'b1;
                                out_score_next = score_cap_reg;
                                if (hits_reg != '1)
                                begin
                                    hits_next = hits_reg + CNT_W'(1);
                                end
                            end
                            else if (miss_reg != '1)
                            begin
                                miss_next = miss_reg + CNT_W'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (found_reg)
                            begin
                                for (int j = 0; j < CACHE_ENTRIES; j++)
                                begin
                                    if (valid_reg[j] && (rank_reg[j] < hit_rank_reg))
                                    begin
                                        rank_next[j] = rank_reg[j] + AW'(1);
                                    end
                                end
                                rank_next[hit_slot_reg] = '0;
                            end
                            else
                            begin
                                // age every other entry, new entry is most recent
                                for (int j = 0; j < CACHE_ENTRIES; j++)
                                begin
                                    if (valid_reg[j] && (AW'(j) != ins_slot))
                                    begin
                                        rank_next[j] = rank_reg[j] + AW'(1);
                                    end
                                end
                                rank_next[ins_slot]  = '0;
                                valid_next[ins_slot] = 1'b1;
                                if (!store_full)
                                begin
                                    fill_next = fill_reg + FW'(1);
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            valid_next = '0;
                            for (int j = 0; j < CACHE_ENTRIES; j++)
                            begin
                                rank_next[j] = '0;
                            end
                            fill_next = '0;
                            hits_next = '0;
                            miss_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_used_next  = USED_W'(fill_next);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cfg_write = psel && penable && pwrite && pready;

    // Hold state, store control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cmp_en_reg    <= 1'b0;
            valid_reg     <= '0;
            for (int j = 0; j < CACHE_ENTRIES; j++)
            begin
                rank_reg[j] <= '0;
            end
            fill_reg      <= '0;
            hits_reg      <= '0;
            miss_reg      <= '0;
            cap_reg       <= CAP_RESET;
            ttl_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_score_reg <= '0;
            out_used_reg  <= '0;
            out_hits_reg  <= '0;
            out_miss_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_en_reg    <= scan_issue;
            valid_reg     <= valid_next;
            rank_reg      <= rank_next;
            fill_reg      <= fill_next;
            hits_reg      <= hits_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
            out_score_reg <= out_score_next;
            out_used_reg  <= out_used_next;
            if (apply_go)
            begin
                out_hits_reg <= hits_next;
                out_miss_reg <= miss_next;
            end
            if (cfg_write)
            begin
                if (paddr[2] == REG_CAPACITY)
                begin
                    cap_reg <= pwdata[CAP_W-1:0];
                end
                else
                begin
                    ttl_reg <= pwdata[TTL_W-1:0];
                end
            end
        end
    end

    // Capture the request, then compare one entry per cycle
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= idx_reg[AW-1:0];
        if (accept)
        begin
            op_reg         <= s_tuser;
            key_reg        <= s_tdata[IN_KEY_LSB +: KEY_W];
            new_score_reg  <= s_tdata[IN_SCORE_LSB +: SCORE_W];
            now_reg        <= s_tdata[IN_NOW_LSB +: TIME_W];
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        if (cmp_en_reg)
        begin
            if (key_match && !found_reg)
            begin
                found_reg     <= 1'b1;
                hit_slot_reg  <= cmp_idx_reg;
                hit_rank_reg  <= rank_reg[cmp_idx_reg];
                score_cap_reg <= score_rd;
                stamp_cap_reg <= stamp_rd;
            end
            if (valid_reg[cmp_idx_reg] && (rank_reg[cmp_idx_reg] == oldest_rank))
            begin
                evict_slot_reg <= cmp_idx_reg;
            end
            if (!valid_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= cmp_idx_reg;
            end
        end
        if (state_reg == ST_CHECK)
        begin
            fresh_reg <= found_reg && ((ttl_reg == '0) || (age <= TIME_W'(ttl_reg)));
        end
    end

    // Register read-back
    always_comb
    begin
        if (paddr[2] == REG_TTL)
        begin
            prdata = 32'(ttl_reg);
        end
        else
        begin
            prdata = 32'(cap_reg);
        end
    end

    assign pready   = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {
        (OUT_DATA_W - OUT_FILL_LSB)'(0),
        out_miss_reg,
        out_hits_reg,
        out_used_reg,
        out_score_reg
    };

endmodule

// ===== hw/rtl/lrc_checker.sv =====
// Port-level checks of the LRU result cache and their binding to the top level.
module lrc_checker
    import lrc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // Drop ready after taking a request: one request in the sequencer at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // Zero score on anything but a hit
    a_miss_score_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[OUT_SCORE_LSB +: SCORE_W] == '0)
        else $error("nonzero score without hit");

    // Keep the fill level within the store
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[OUT_USED_LSB +: USED_W]) <= 32'(CACHE_ENTRIES))
        else $error("fill level above store size");

endmodule

bind lru_result_cache_ttl lrc_checker #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_lrc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/lru_result_cache_ttl_tb.sv =====
// Self-checking testbench for the LRU result cache with entry time-to-live.
`timescale 1ns / 100ps

module lru_result_cache_ttl_tb;
    import lrc_pkg::*;

    localparam int ENTRIES = 16;
    localparam int DRAIN_CYCLES = ENTRIES + 8;

    // Opcode with no function, and byte addresses of the two registers
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    localparam logic [2:0] ADDR_TTL      = {REG_TTL, 2'b00};

    typedef enum bit {ROW_REQUEST, ROW_CONFIG} row_kind_t;

    typedef struct {
        logic                hit;
        logic [SCORE_W-1:0]  score;
        logic [USED_W-1:0]   used;
        logic [CNT_W-1:0]    hits;
        logic [CNT_W-1:0]    misses;
    } answer_t;

    typedef struct {
        row_kind_t           kind;
        logic [2:0]          addr;
        logic [31:0]         value;
        logic [OP_W-1:0]     op;
        logic [KEY_W-1:0]    key;
        logic [SCORE_W-1:0]  score;
        logic [TIME_W-1:0]   now;
        bit                  known;
        answer_t             want;
    } script_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    lru_result_cache_ttl #(
        .CACHE_ENTRIES(ENTRIES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the cache contents and registers
    logic [KEY_W-1:0]   c_key   [ENTRIES];
    logic [SCORE_W-1:0] c_score [ENTRIES];
    logic [TIME_W-1:0]  c_stamp [ENTRIES];
    bit                 c_valid [ENTRIES];
    int                 c_rank  [ENTRIES];
    logic [CNT_W-1:0]   c_hits;
    logic [CNT_W-1:0]   c_misses;
    logic [CAP_W-1:0]   c_cap;
    logic [TTL_W-1:0]   c_ttl;

    answer_t     pending_answers[$];
    script_row_t script[$];
    int          mismatches;
    bit          src_idle_en;
    bit          snk_idle_en;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("lru_result_cache_ttl_tb NOT OK");
        $finish;
    end

    function automatic int count_valid();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (c_valid[i])
                n++;
        return n;
    endfunction

    // Move a slot to most recent, aging everything that was newer
    function automatic void promote_entry(int s);
        int r;
        r = c_rank[s];
        for (int j = 0; j < ENTRIES; j++)
            if (c_valid[j] && c_rank[j] < r)
                c_rank[j]++;
        c_rank[s] = 0;
    endfunction

    function automatic void clear_cache();
        for (int i = 0; i < ENTRIES; i++)
        begin
            c_valid[i] = 1'b0;
            c_rank[i]  = 0;
        end
        c_hits   = '0;
        c_misses = '0;
    endfunction

    // Apply one request to the shadow cache and return its result word
    function automatic answer_t apply_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                              logic [SCORE_W-1:0] score,
                                              logic [TIME_W-1:0] now);
        answer_t a;
        int slot;
        int victim;
        int limit;
        logic [TIME_W-1:0] age;
        bit fresh;
        a = '{1'b0, '0, '0, '0, '0};
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && c_valid[i] && c_key[i] == key)
                slot = i;
        case (op)
            OP_LOOKUP:
            begin
                fresh = 1'b0;
                if (slot >= 0)
                begin
                    age = now - c_stamp[slot];
                    fresh = (c_ttl == '0) || (age <= {1'b0, c_ttl});
                end
                if (fresh)
                begin
                    promote_entry(slot);
                    a.hit = 1'b1;
                    a.score = c_score[slot];
                    if (c_hits != '1)
                        c_hits++;
                end
                else if (c_misses != '1)
                    c_misses++;
            end
            OP_INSERT:
            begin
                if (slot >= 0)
                begin
                    c_score[slot] = score;
                    c_stamp[slot] = now;
                    promote_entry(slot);
                end
                else
                begin
                    limit = (c_cap == 0) ? 1 : (c_cap > ENTRIES) ? ENTRIES : int'(c_cap);
                    victim = -1;
                    // evict the oldest slot when full
                    if (count_valid() >= limit)
                    begin
                        for (int j = 0; j < ENTRIES; j++)
                            if (c_valid[j] && (victim < 0 || c_rank[j] > c_rank[victim]))
                                victim = j;
                        if (victim >= 0)
                            c_valid[victim] = 1'b0;
                    end
                    if (victim < 0)
                        for (int j = 0; j < ENTRIES; j++)
                            if (victim < 0 && !c_valid[j])
                                victim = j;
                    if (victim >= 0)
                    begin
                        for (int j = 0; j < ENTRIES; j++)
                            if (c_valid[j])
                                c_rank[j]++;
                        c_key[victim]   = key;
                        c_score[victim] = score;
                        c_stamp[victim] = now;
                        c_valid[victim] = 1'b1;
                        c_rank[victim]  = 0;
                    end
                end
            end
            OP_CLEAR:
                clear_cache();
            default:
                ;
        endcase
        a.used   = USED_W'(count_valid());
        a.hits   = c_hits;
        a.misses = c_misses;
        return a;
    endfunction

    function automatic script_row_t make_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                             logic [SCORE_W-1:0] score,
                                             logic [TIME_W-1:0] now);
        script_row_t r;
        r.kind  = ROW_REQUEST;
        r.addr  = '0;
        r.value = '0;
        r.op    = op;
        r.key   = key;
        r.score = score;
        r.now   = now;
        r.known = 1'b0;
        r.want  = '{1'b0, '0, '0, '0, '0};
        return r;
    endfunction

    function automatic void add_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                    logic [SCORE_W-1:0] score, logic [TIME_W-1:0] now);
        script.push_back(make_req(op, key, score, now));
    endfunction

    function automatic void add_known(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                      logic [SCORE_W-1:0] score, logic [TIME_W-1:0] now,
                                      logic hit, logic [SCORE_W-1:0] score_o,
                                      logic [USED_W-1:0] used, logic [CNT_W-1:0] hits,
                                      logic [CNT_W-1:0] misses);
        script_row_t r;
        r = make_req(op, key, score, now);
        r.known = 1'b1;
        r.want  = '{hit, score_o, used, hits, misses};
        script.push_back(r);
    endfunction

    function automatic void add_cfg(logic [2:0] addr, logic [31:0] value);
        script_row_t r;
        r = make_req(OP_UNUSED, '0, '0, '0);
        r.kind  = ROW_CONFIG;
        r.addr  = addr;
        r.value = value;
        script.push_back(r);
    endfunction

    // Present one request word and hold it until accepted
    task automatic issue_request(script_row_t row);
        answer_t ans;
        int gap;
        ans = apply_request(row.op, row.key, row.score, row.now);
        if (row.known)
            ans = row.want;
        pending_answers.push_back(ans);
        gap = src_idle_en ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.op;
        s_tdata  <= {row.now, row.score, row.key};
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
    endtask

    // Hold off the sender until every result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup and access phases, then the bus returns to idle
    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (addr[2] == REG_CAPACITY)
            c_cap = value[CAP_W-1:0];
        else
            c_ttl = value[TTL_W-1:0];
    endtask

    // Result side: stall at random, take each word and check it
    initial
    begin
        answer_t got;
        answer_t want;
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = snk_idle_en ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (!m_tvalid);
            got.hit    = m_tuser;
            got.score  = m_tdata[OUT_SCORE_LSB +: SCORE_W];
            got.used   = m_tdata[OUT_USED_LSB +: USED_W];
            got.hits   = m_tdata[OUT_HITS_LSB +: CNT_W];
            got.misses = m_tdata[OUT_MISS_LSB +: CNT_W];
            @(posedge clk);
            if (pending_answers.size() == 0)
            begin
                $display("%0t: result word with no request waiting: hit %0d score %h",
                         $time, got.hit, got.score);
                mismatches++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                    mismatches++;
                end
                if (got.score !== want.score)
                begin
                    $display("%0t: score_out expected %h actual %h",
                             $time, want.score, got.score);
                    mismatches++;
                end
                if (got.used !== want.used)
                begin
                    $display("%0t: entries_used expected %0d actual %0d",
                             $time, want.used, got.used);
                    mismatches++;
                end
                if (got.hits !== want.hits)
                begin
                    $display("%0t: hit_count expected %0d actual %0d",
                             $time, want.hits, got.hits);
                    mismatches++;
                end
                if (got.misses !== want.misses)
                begin
                    $display("%0t: miss_count expected %0d actual %0d",
                             $time, want.misses, got.misses);
                    mismatches++;
                end
            end
        end
    end

    // Reset, directed script, then random phases
    initial
    begin
        logic [KEY_W-1:0]  key_pool[12];
        logic [TIME_W-1:0] clock_ms;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [31:0]       cap_pick;
        logic [31:0]       ttl_pick;
        int                cap_list[6];
        int                ttl_list[6];
        int                r;

        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_LOOKUP;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rst_n    <= 1'b0;
        mismatches = 0;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        clear_cache();
        c_cap = CAP_RESET;
        c_ttl = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: capacity 16, no expiry
        add_known(OP_LOOKUP, '0, '0, '0, 0, '0, 0, 0, 1);
        add_known(OP_INSERT, '1, '1, '1, 0, '0, 1, 0, 1);
        add_known(OP_LOOKUP, '1, '0, '0, 1, '1, 1, 1, 1);
        add_known(OP_INSERT, '0, '0, '0, 0, '0, 2, 1, 1);
        add_known(OP_LOOKUP, '0, '1, '1, 1, '0, 2, 2, 1);
        add_known(OP_UNUSED, 64'hDEAD_BEEF_0BAD_F00D, '1, 32'h1234, 0, '0, 2, 2, 1);
        add_known(OP_INSERT, '1, 64'h5555_5555_5555_5555, '0, 0, '0, 2, 2, 1);
        add_known(OP_LOOKUP, '1, '0, '0, 1, 64'h5555_5555_5555_5555, 2, 3, 1);
        add_known(OP_CLEAR, '1, '1, '1, 0, '0, 0, 0, 0);
        add_known(OP_LOOKUP, '1, '0, '0, 0, '0, 0, 0, 1);
        // Eviction at capacity two and expiry at the age boundary, wrapped too
        add_cfg(ADDR_CAPACITY, 32'd2);
        add_cfg(ADDR_TTL, 32'd10);
        add_req(OP_INSERT, 64'hA1, 64'h1111, 32'd100);
        add_req(OP_INSERT, 64'hA2, 64'h2222, 32'd100);
        add_req(OP_INSERT, 64'hA3, 64'h3333, 32'd100);
        add_req(OP_LOOKUP, 64'hA1, '0, 32'd100);
        add_req(OP_LOOKUP, 64'hA2, '0, 32'd110);
        add_req(OP_LOOKUP, 64'hA3, '0, 32'd111);
        add_req(OP_INSERT, 64'hA3, 64'h3434, 32'hFFFF_FFFA);
        add_req(OP_LOOKUP, 64'hA3, '0, 32'd4);
        // Capacity zero acts as one; lowering it below the fill evicts one per insert
        add_cfg(ADDR_CAPACITY, 32'd0);
        add_req(OP_INSERT, 64'hA5, 64'h5555, 32'd4);
        add_req(OP_LOOKUP, 64'hA2, '0, 32'd4);
        // Capacity above the store size, largest time-to-live
        add_cfg(ADDR_CAPACITY, 32'd31);
        add_cfg(ADDR_TTL, 32'h7FFF_FFFF);
        add_req(OP_LOOKUP, 64'hA5, '0, 32'd4 + 32'h7FFF_FFFF);
        add_req(OP_LOOKUP, 64'hA3, '0, 32'd4 + 32'h8000_0000);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CONFIG)
            begin
                drain_results();
                write_register(script[i].addr, script[i].value);
            end
            else
                issue_request(script[i]);
        end

        // Random phases, each with its own register setting and key pool
        cap_list = '{1, 0, 31, 17, 2, 16};
        ttl_list = '{0, 5, 32'h7FFF_FFFF, 1, 20, 0};
        for (int phase = 0; phase < 16; phase++)
        begin
            drain_results();
            if (phase < 6)
            begin
                cap_pick = cap_list[phase];
                ttl_pick = ttl_list[phase];
            end
            else
            begin
                cap_pick = $urandom_range(0, 31);
                ttl_pick = $urandom_range(0, 1) ? $urandom_range(0, 40)
                                                : ($urandom & 32'h7FFF_FFFF);
            end
            write_register(ADDR_CAPACITY, cap_pick);
            write_register(ADDR_TTL, ttl_pick);
            src_idle_en = ($urandom_range(0, 3) != 0);
            snk_idle_en = ($urandom_range(0, 3) != 0);
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int k = 2; k < 12; k++)
                key_pool[k] = {$urandom, $urandom};
            clock_ms = $urandom;
            for (int n = 0; n < 100; n++)
            begin
                r = $urandom_range(0, 99);
                op = (r < 50) ? OP_LOOKUP : (r < 94) ? OP_INSERT : (r < 97) ? OP_CLEAR
                                                                            : OP_UNUSED;
                key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                  : key_pool[$urandom_range(0, 11)];
                // advance time slowly, with rare big jumps
                r = $urandom_range(0, 99);
                if (r < 2)
                    clock_ms = clock_ms + 32'h8000_0000 + $urandom_range(0, 3);
                else if (r < 4)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, 6);
                if (n == 50 && phase[0])
                    drain_results();
                issue_request(make_req(op, key, {$urandom, $urandom}, clock_ms));
            end
        end

        // Wait out the last results
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("lru_result_cache_ttl_tb OK");
        else
            $display("lru_result_cache_ttl_tb NOT OK");
        $finish;
    end

endmodule

// ===== lru_result_cache_ttl.f =====
hw/rtl/lrc_pkg.sv
hw/rtl/lrc_ram.sv
hw/rtl/lru_result_cache_ttl.sv
hw/rtl/lrc_checker.sv
dv/lru_result_cache_ttl_tb.sv
